/* src/uart_command_frame_parser_top_macros.svh */
// assertion macros for the uart command frame parser top level
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef UART_COMMAND_FRAME_PARSER_TOP_MACROS_SVH
`define UART_COMMAND_FRAME_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define UCFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define UCFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ucfp_pkg.sv */
// shared constants and types for the uart command frame parser
// no dependencies
`timescale 1ns / 1ps

package ucfp_pkg;

    localparam logic [7:0] BYTE_WAVE_START  = 8'hEA;
    localparam logic [7:0] BYTE_CONN_START  = 8'hAA;
    localparam logic [7:0] BYTE_CLEAR_START = 8'h9F;
    localparam logic [7:0] BYTE_WAVE_END    = 8'hFA;
    localparam logic [7:0] BYTE_CONN_END    = 8'hF5;

    typedef enum logic [1:0] {
        KIND_WAVE  = 2'd0,
        KIND_CONN  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_DROP  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       command_kind;
        logic [7:0]  wave_code;
        logic [31:0] frequency_bytes;
        logic [31:0] amplitude_bytes;
        logic [7:0]  point_a;
        logic [7:0]  point_b;
    } t_result;

    typedef struct packed {
        logic take;
        logic idle;
        logic res_valid;
    } t_core_status;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } t_buf_status;

endpackage

/* src/ucfp_if.sv */
// valid/ready channel interfaces for received bytes and parsed commands
// depends on ucfp_pkg
`timescale 1ns / 1ps

interface ucfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfp_out_if;
    logic                valid;
    logic                ready;
    ucfp_pkg::t_kind     command_kind;
    logic [7:0]          wave_code;
    logic [31:0]         frequency_bytes;
    logic [31:0]         amplitude_bytes;
    logic [7:0]          point_a;
    logic [7:0]          point_b;

    modport source (output valid, output command_kind, output wave_code,
                    output frequency_bytes, output amplitude_bytes,
                    output point_a, output point_b, input ready);
    modport sink   (input valid, input command_kind, input wave_code,
                    input frequency_bytes, input amplitude_bytes,
                    input point_a, input point_b, output ready);
endinterface

/* src/ucfp_in_reg.sv */
// input register stage: holds one received byte for the parser
// depends on ucfp_in_if
`timescale 1ns / 1ps

module ucfp_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ucfp_in_if.sink       i_in,
    input  logic          i_take,
    output logic          o_valid,
    output logic [7:0]    o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    // refill in the same cycle the parser consumes the held item
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

/* src/ucfp_core.sv */
// frame parser: state machine and collected frame bytes
// depends on ucfp_pkg
`timescale 1ns / 1ps

module ucfp_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_byte,
    input  logic                   i_buf_ready,
    output logic                   o_take,
    output logic                   o_res_valid,
    output ucfp_pkg::t_result      o_res,
    output ucfp_pkg::t_core_status o_status
);
    import ucfp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_PA   = 4'd1,
        ST_PB   = 4'd2,
        ST_CLR  = 4'd3,
        ST_WAVE = 4'd4,
        ST_F1   = 4'd5,
        ST_F2   = 4'd6,
        ST_F3   = 4'd7,
        ST_F4   = 4'd8,
        ST_A1   = 4'd9,
        ST_A2   = 4'd10,
        ST_A3   = 4'd11,
        ST_A4   = 4'd12,
        ST_TERM = 4'd13
    } t_state;

    t_state      r_state, n_state;
    logic        r_conn, n_conn;
    logic [7:0]  r_wave, n_wave;
    logic [31:0] r_freq, n_freq;
    logic [31:0] r_amp, n_amp;
    logic [7:0]  r_pa, n_pa;
    logic [7:0]  r_pb, n_pb;
    logic        n_res_valid;
    t_result     n_res;

    assign o_take = i_valid && i_buf_ready;

    always_comb begin
        n_state     = r_state;
        n_conn      = r_conn;
        n_wave      = r_wave;
        n_freq      = r_freq;
        n_amp       = r_amp;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_res_valid = 1'b0;
        n_res       = '0;
        case (r_state) inside
            ST_IDLE: begin
                if (i_byte == BYTE_WAVE_START) begin
                    n_conn  = 1'b0;
                    n_state = ST_WAVE;
                end else if (i_byte == BYTE_CONN_START) begin
                    n_conn  = 1'b1;
                    n_state = ST_PA;
                end else if (i_byte == BYTE_CLEAR_START) begin
                    n_state = ST_CLR;
                end
            end
            ST_PA: begin
                n_pa    = i_byte;
                n_state = ST_PB;
            end
            ST_PB: begin
                n_pb    = i_byte;
                n_state = ST_TERM;
            end
            ST_CLR: begin
                n_state            = ST_IDLE;
                n_res_valid        = 1'b1;
                n_res.command_kind = KIND_CLEAR;
            end
            ST_WAVE: begin
                n_wave  = i_byte;
                n_state = ST_F1;
            end
            [ST_F1:ST_F4]: begin
                n_freq  = {r_freq[23:0], i_byte};
                n_state = t_state'(r_state + 4'd1);
            end
            [ST_A1:ST_A4]: begin
                n_amp   = {r_amp[23:0], i_byte};
                n_state = t_state'(r_state + 4'd1);
            end
            ST_TERM: begin
                n_state     = ST_IDLE;
                n_res_valid = 1'b1;
                // the other frame's terminator counts as a wrong one
                if (!r_conn && i_byte == BYTE_WAVE_END) begin
                    n_res.command_kind    = KIND_WAVE;
                    n_res.wave_code       = r_wave;
                    n_res.frequency_bytes = r_freq;
                    n_res.amplitude_bytes = r_amp;
                end else if (r_conn && i_byte == BYTE_CONN_END) begin
                    n_res.command_kind = KIND_CONN;
                    n_res.point_a      = r_pa;
                    n_res.point_b      = r_pb;
                end else begin
                    n_res.command_kind = KIND_DROP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_conn  <= 1'b0;
            r_wave  <= '0;
            r_freq  <= '0;
            r_amp   <= '0;
            r_pa    <= '0;
            r_pb    <= '0;
        end else if (o_take) begin
            r_state <= n_state;
            r_conn  <= n_conn;
            r_wave  <= n_wave;
            r_freq  <= n_freq;
            r_amp   <= n_amp;
            r_pa    <= n_pa;
            r_pb    <= n_pb;
        end
    end

    assign o_res_valid        = o_take && n_res_valid;
    assign o_res              = n_res;
    assign o_status.take      = o_take;
    assign o_status.idle      = (r_state == ST_IDLE);
    assign o_status.res_valid = o_res_valid;
endmodule

/* src/ucfp_out_buf.sv */
// result register with a skid entry in front of the output channel
// depends on ucfp_pkg and ucfp_out_if
`timescale 1ns / 1ps

module ucfp_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_res_valid,
    input  ucfp_pkg::t_result     i_res,
    output logic                  o_ready,
    ucfp_out_if.source            o_out,
    output ucfp_pkg::t_buf_status o_status
);
    import ucfp_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign o_ready = !r_skid_valid;
    assign pop     = r_main_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (i_res_valid) begin
                r_main <= i_res;
            end else begin
                r_main_valid <= 1'b0;
            end
        end else if (i_res_valid) begin
            // push only arrives while the skid entry is free
            if (!r_main_valid) begin
                r_main       <= i_res;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_out.valid           = r_main_valid;
    assign o_out.command_kind    = r_main.command_kind;
    assign o_out.wave_code       = r_main.wave_code;
    assign o_out.frequency_bytes = r_main.frequency_bytes;
    assign o_out.amplitude_bytes = r_main.amplitude_bytes;
    assign o_out.point_a         = r_main.point_a;
    assign o_out.point_b         = r_main.point_b;

    assign o_status.main_valid = r_main_valid;
    assign o_status.skid_valid = r_skid_valid;
endmodule

/* src/uart_command_frame_parser_top.sv */
// top level of the uart command frame parser
// depends on ucfp_pkg, ucfp_if, ucfp_in_reg, ucfp_core, ucfp_out_buf and the macros header
`timescale 1ns / 1ps

// Parses received serial bytes into waveform, connect and clear commands, one byte
// per clock while the output side keeps up. The byte that completes a frame passes
// through the input register, and its result then goes into the result register,
// which drives the output. The result register has a skid entry, so bytes keep
// flowing while one result waits; a second result goes into the skid entry, and
// then the input stalls until the output is taken. Wrong terminators give a drop
// result, unrecognized bytes in idle are ignored and give no result.
module uart_command_frame_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ucfp_in_if.sink     i_in,
    ucfp_out_if.source  o_out
);
    import ucfp_pkg::*;
    `include "uart_command_frame_parser_top_macros.svh"

    logic         in_valid;
    logic [7:0]   in_byte;
    logic         take;
    logic         buf_ready;
    logic         res_valid;
    t_result      res;
    t_core_status core_status;
    t_buf_status  buf_status;

    ucfp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    ucfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .i_buf_ready (buf_ready),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_status    (core_status)
    );

    ucfp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_ready     (buf_ready),
        .o_out       (o_out),
        .o_status    (buf_status)
    );

    // a start or ignored byte in idle never yields a result
    `UCFP_ASSERT_NOW(a_idle_no_result, core_status.take && core_status.idle, !core_status.res_valid, "result from an idle byte")
    // the skid entry is only used behind a full result register
    `UCFP_ASSERT_NOW(a_skid_behind_main, buf_status.skid_valid, buf_status.main_valid, "skid entry without main entry")
    // input stalls only when the skid entry is occupied
    `UCFP_ASSERT_NOW(a_stall_cause, !i_in.ready, buf_status.skid_valid && in_valid, "input stalled without a full buffer")
    // a result pushed into an empty buffer shows on the output next cycle
    `UCFP_ASSERT_NEXT(a_result_shows, core_status.res_valid && !buf_status.main_valid, o_out.valid, "result lost")
endmodule
